// ===== rtl/rs_gf929_known_position_decoder_unit_macros.svh =====
// Assertion helpers shared by the decoder modules.
// Each module that uses them has ports named clock and reset.
`ifndef RS_GF929_KNOWN_POSITION_DECODER_UNIT_MACROS_SVH
`define RS_GF929_KNOWN_POSITION_DECODER_UNIT_MACROS_SVH

// The condition implies the property in the same cycle.
`define RSGF_IMPLY(name, cond, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("decoder check failed");

// The condition implies the property in the next cycle.
`define RSGF_NEXT(name, cond, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("decoder check failed");

`endif

// ===== rtl/rsgf_pkg.sv =====
package rsgf_pkg;

   localparam int SYM_W        = 10;
   localparam int POS_W        = 3;
   localparam int CODE_LENGTH  = 7;
   localparam int PARITY_COUNT = 4;
   localparam int QUEUE_DEPTH  = 2;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [SYM_W-1:0] PRIME   = 10'd929;
   // 1024 mod 929, used to fold the high part of a product back down.
   localparam logic [6:0]       FOLD    = 7'd95;
   // Exponent p - 2 gives the multiplicative inverse.
   localparam logic [SYM_W-1:0] INV_EXP = 10'd927;
   localparam logic [POS_W-1:0] LAST_POS = 3'd6;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_GENERATOR = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERRORS    = 1'b1;

   typedef struct packed {
      logic [SYM_W-1:0] generator;
      logic [1:0]       errors_assumed;
   } cfg_type;

   // One codeword handed from the front to the back.
   typedef struct packed {
      logic [CODE_LENGTH-1:0][SYM_W-1:0] word;
      logic [POS_W-1:0]                  pos_a;
      logic [POS_W-1:0]                  pos_b;
   } job_type;

   // Operands of the shared multiply-add unit: a * b + c mod p.
   typedef struct packed {
      logic [SYM_W-1:0] a;
      logic [SYM_W-1:0] b;
      logic [SYM_W-1:0] c;
   } mul_req_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_INIT, ST_AINV_SAVE, ST_SYN_BETA, ST_SYN_ACC, ST_SYN_STORE,
      ST_PIV0, ST_A01, ST_A02, ST_B11, ST_B12, ST_PIV1, ST_C12, ST_L2,
      ST_OM1, ST_OM2A, ST_OM2B, ST_OM3A, ST_OM3B,
      ST_FN_POS, ST_FN_HORNER, ST_FN_DL, ST_FN_EV, ST_EMIT,
      ST_PW_TEST, ST_PW_MUL, ST_PW_SQ
   } seq_state_type;

   // Reduce a value below 2^20 modulo p by folding 2^10 = 95 (mod p).
   function automatic logic [SYM_W-1:0] fred(input logic [19:0] v);
      logic [16:0] f1;
      logic [13:0] f2;
      logic [11:0] f3;
      logic [10:0] f4;
      f1 = 17'(v[19:10]) * 17'(FOLD) + 17'(v[9:0]);
      f2 = 14'(f1[16:10]) * 14'(FOLD) + 14'(f1[9:0]);
      f3 = 12'(f2[13:10]) * 12'(FOLD) + 12'(f2[9:0]);
      f4 = 11'(f3[11:10]) * 11'(FOLD) + 11'(f3[9:0]);
      return (f4 >= 11'(PRIME)) ? 10'(f4 - 11'(PRIME)) : f4[9:0];
   endfunction

   // Bring a raw 10-bit value into the field.
   function automatic logic [SYM_W-1:0] fnorm(input logic [SYM_W-1:0] v);
      return (v >= PRIME) ? 10'(v - PRIME) : v;
   endfunction

   function automatic logic [SYM_W-1:0] fadd(input logic [SYM_W-1:0] a,
                                             input logic [SYM_W-1:0] b);
      logic [SYM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s >= {1'b0, PRIME}) ? 10'(s - {1'b0, PRIME}) : s[SYM_W-1:0];
   endfunction

   function automatic logic [SYM_W-1:0] fsub(input logic [SYM_W-1:0] a,
                                             input logic [SYM_W-1:0] b);
      logic [SYM_W:0] d;
      d = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, PRIME} - {1'b0, b});
      return d[SYM_W-1:0];
   endfunction

   function automatic logic [SYM_W-1:0] fneg(input logic [SYM_W-1:0] b);
      return (b == '0) ? '0 : 10'(PRIME - b);
   endfunction

endpackage

// ===== rtl/rsgf_front.sv =====
module rsgf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [9:0]           req_symbol,
   input  logic [2:0]           req_first_error_position,
   input  logic [2:0]           req_second_error_position,
   input  logic                 req_end_of_word,
   input  logic                 q_full,
   output logic                 push,
   output rsgf_pkg::job_type    job
);
   import rsgf_pkg::*;

   logic [SYM_W-1:0] store_ff [CODE_LENGTH];
   logic [POS_W-1:0] count_ff;
   logic [POS_W-1:0] count_in;
   logic [SYM_W-1:0] sym;
   logic             accept;

   // The front holds off everything while the job queue is full.
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign push      = accept && req_end_of_word;
   assign sym       = fnorm(req_symbol);

   // The job snapshot sees the incoming symbol in its slot.
   always_comb begin
      for (int k = 0; k < CODE_LENGTH; k++) begin
         job.word[k] = (count_ff == POS_W'(k)) ? sym : store_ff[k];
      end
      job.pos_a = req_first_error_position;
      job.pos_b = req_second_error_position;
   end

   // Write index wraps after a full word and restarts after each end of word.
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req_end_of_word || count_ff == LAST_POS) begin
            count_in = '0;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Received symbols stay until overwritten, so a short word reuses them.
   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff[count_ff] <= sym;
      end
   end

endmodule

// ===== rtl/rsgf_queue.sv =====
`include "rs_gf929_known_position_decoder_unit_macros.svh"

module rsgf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rsgf_pkg::job_type  push_job,
   input  logic               pop,
   output logic               full,
   output logic               q_valid,
   output rsgf_pkg::job_type  q_head
);
   import rsgf_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   job_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full    = (count_ff == FULL_CNT);
   assign q_valid = (count_ff != '0);
   assign q_head  = entry_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `RSGF_IMPLY(a_no_push_when_full, push, count_ff != FULL_CNT)
   `RSGF_IMPLY(a_no_pop_when_empty, pop, count_ff != '0)
   `RSGF_NEXT(a_push_leaves_entry, push && !pop, count_ff != '0)

endmodule

// ===== rtl/rsgf_mul.sv =====
module rsgf_mul (
   input  logic                  clock,
   input  rsgf_pkg::mul_req_type req,
   output logic [9:0]            result
);
   import rsgf_pkg::*;

   logic [19:0]      prod_ff;
   logic [SYM_W-1:0] addend_ff;

   // Product and addend are registered; the add and the reduction are combinational on them.
   always_ff @(posedge clock) begin
      prod_ff   <= 20'(req.a) * 20'(req.b);
      addend_ff <= req.c;
   end

   assign result = fred(prod_ff + 20'(addend_ff));

endmodule

// ===== rtl/rsgf_back.sv =====
`include "rs_gf929_known_position_decoder_unit_macros.svh"

module rsgf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  rsgf_pkg::cfg_type     cfg,
   input  logic                  q_valid,
   input  rsgf_pkg::job_type     q_head,
   output logic                  pop,
   output rsgf_pkg::mul_req_type mul_req,
   input  logic [9:0]            mul_res,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [9:0]            rsp_corrected_symbol,
   output logic                  rsp_last_of_run
);
   import rsgf_pkg::*;

   seq_state_type    state_ff, state_in, ret_ff;
   logic             ph_ff;
   logic [1:0]       i_ff;
   logic [POS_W-1:0] j_ff;
   logic             fi_ff;
   logic [1:0]       hk_ff;
   logic [POS_W-1:0] oc_ff;
   logic [SYM_W-1:0] beta_ff, acc_ff, ainv_ff;
   logic [SYM_W-1:0] s_ff [PARITY_COUNT];
   logic [SYM_W-1:0] a01_ff, a02_ff, b11_ff, b12_ff, l1_ff, l2_ff;
   logic [SYM_W-1:0] om1_ff, om2_ff, om3_ff, dl_ff;
   logic [SYM_W-1:0] ev_ff [CODE_LENGTH];
   logic [SYM_W-1:0] pw_base_ff, pw_exp_ff, pw_res_ff;
   logic             rsp_valid_ff, rsp_last_ff;
   logic [SYM_W-1:0] rsp_sym_ff;

   logic             e2;
   logic [SYM_W-1:0] alpha;
   logic [1:0]       syn_last;
   logic [POS_W-1:0] pos_cur;
   logic             pos_ok;
   logic [SYM_W-1:0] om_sel;
   logic [SYM_W-1:0] l2x2;
   logic             mul_state;
   logic             load_out;

   // Two errors for settings 2 and 3, one for 0 and 1.
   assign e2       = cfg.errors_assumed[1];
   assign alpha    = fnorm(cfg.generator);
   assign syn_last = e2 ? 2'd3 : 2'd1;
   assign pos_cur  = fi_ff ? q_head.pos_b : q_head.pos_a;
   assign pos_ok   = (pos_cur <= LAST_POS);
   assign l2x2     = e2 ? fadd(l2_ff, l2_ff) : '0;

   always_comb begin
      case (hk_ff)
         2'd3:    om_sel = om3_ff;
         2'd2:    om_sel = om2_ff;
         2'd1:    om_sel = om1_ff;
         default: om_sel = s_ff[0];
      endcase
   end

   // States that use the multiplier, with an issue phase and a capture phase.
   assign mul_state = state_ff inside {ST_SYN_BETA, ST_SYN_ACC, ST_A01, ST_A02, ST_B11,
                                       ST_B12, ST_C12, ST_L2, ST_OM1, ST_OM2A, ST_OM2B,
                                       ST_OM3A, ST_OM3B, ST_FN_HORNER, ST_FN_DL,
                                       ST_FN_EV, ST_PW_MUL, ST_PW_SQ};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (q_valid) state_in = ST_INIT;
         ST_INIT:      state_in = ST_PW_TEST;
         ST_AINV_SAVE: state_in = ST_SYN_BETA;
         ST_SYN_BETA:  if (ph_ff) state_in = ST_SYN_ACC;
         ST_SYN_ACC:   if (ph_ff && j_ff == LAST_POS) state_in = ST_SYN_STORE;
         ST_SYN_STORE: state_in = (i_ff == syn_last) ? ST_PIV0 : ST_SYN_BETA;
         ST_PIV0:      state_in = ST_PW_TEST;
         ST_A01:       if (ph_ff) state_in = ST_A02;
         ST_A02:       if (ph_ff) state_in = e2 ? ST_B11 : ST_OM1;
         ST_B11:       if (ph_ff) state_in = ST_B12;
         ST_B12:       if (ph_ff) state_in = ST_PIV1;
         ST_PIV1:      state_in = ST_PW_TEST;
         ST_C12:       if (ph_ff) state_in = ST_L2;
         ST_L2:        if (ph_ff) state_in = ST_OM1;
         ST_OM1:       if (ph_ff) state_in = e2 ? ST_OM2A : ST_FN_POS;
         ST_OM2A:      if (ph_ff) state_in = ST_OM2B;
         ST_OM2B:      if (ph_ff) state_in = ST_OM3A;
         ST_OM3A:      if (ph_ff) state_in = ST_OM3B;
         ST_OM3B:      if (ph_ff) state_in = ST_FN_POS;
         ST_FN_POS: begin
            if (pos_ok) begin
               state_in = ST_PW_TEST;
            end else if (fi_ff == e2) begin
               state_in = ST_EMIT;
            end
         end
         ST_FN_HORNER: if (ph_ff && hk_ff == 2'd0) state_in = ST_FN_DL;
         ST_FN_DL:     if (ph_ff) state_in = ST_PW_TEST;
         ST_FN_EV:     if (ph_ff) state_in = (fi_ff == e2) ? ST_EMIT : ST_FN_POS;
         ST_EMIT:      if (load_out && oc_ff == LAST_POS) state_in = ST_IDLE;
         ST_PW_TEST: begin
            if (pw_exp_ff == '0) begin
               state_in = ret_ff;
            end else begin
               state_in = pw_exp_ff[0] ? ST_PW_MUL : ST_PW_SQ;
            end
         end
         ST_PW_MUL:    if (ph_ff) state_in = ST_PW_SQ;
         ST_PW_SQ:     if (ph_ff) state_in = ST_PW_TEST;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Multiplier operands, result load and queue pop.
   always_comb begin
      mul_req  = '0;
      load_out = 1'b0;
      pop      = 1'b0;
      case (state_ff)
         ST_SYN_BETA:  begin mul_req.a = beta_ff;  mul_req.b = alpha; end
         ST_SYN_ACC: begin
            mul_req.a = acc_ff;
            mul_req.b = beta_ff;
            mul_req.c = q_head.word[j_ff];
         end
         ST_A01:       begin mul_req.a = s_ff[1]; mul_req.b = pw_res_ff; end
         ST_A02: begin
            mul_req.a = e2 ? fneg(s_ff[2]) : fneg(s_ff[1]);
            mul_req.b = pw_res_ff;
         end
         ST_B11: begin
            mul_req.a = a01_ff; mul_req.b = fneg(s_ff[1]); mul_req.c = s_ff[2];
         end
         ST_B12: begin
            mul_req.a = a02_ff; mul_req.b = fneg(s_ff[1]); mul_req.c = fneg(s_ff[3]);
         end
         ST_C12:       begin mul_req.a = b12_ff; mul_req.b = pw_res_ff; end
         ST_L2: begin
            mul_req.a = a01_ff; mul_req.b = fneg(l1_ff); mul_req.c = a02_ff;
         end
         ST_OM1:  begin mul_req.a = s_ff[0]; mul_req.b = l1_ff; mul_req.c = s_ff[1]; end
         ST_OM2A: begin mul_req.a = s_ff[1]; mul_req.b = l1_ff; mul_req.c = s_ff[2]; end
         ST_OM2B: begin mul_req.a = s_ff[0]; mul_req.b = l2_ff; mul_req.c = om2_ff;  end
         ST_OM3A: begin mul_req.a = s_ff[2]; mul_req.b = l1_ff; mul_req.c = s_ff[3]; end
         ST_OM3B: begin mul_req.a = s_ff[1]; mul_req.b = l2_ff; mul_req.c = om3_ff;  end
         ST_FN_HORNER: begin
            mul_req.a = acc_ff; mul_req.b = pw_res_ff; mul_req.c = om_sel;
         end
         ST_FN_DL: begin
            mul_req.a = l2x2; mul_req.b = pw_res_ff; mul_req.c = l1_ff;
         end
         ST_FN_EV:     begin mul_req.a = fneg(acc_ff); mul_req.b = pw_res_ff; end
         ST_PW_MUL:    begin mul_req.a = pw_res_ff; mul_req.b = pw_base_ff; end
         ST_PW_SQ:     begin mul_req.a = pw_base_ff; mul_req.b = pw_base_ff; end
         ST_EMIT: begin
            load_out = !rsp_valid_ff || !rsp_stall;
            pop      = load_out && (oc_ff == LAST_POS);
         end
         default: begin
            mul_req = '0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         ph_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= mul_state ? !ph_ff : 1'b0;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_INIT: ret_ff <= ST_AINV_SAVE;
            ST_PIV0: ret_ff <= e2 ? ST_A01 : ST_A02;
            ST_PIV1: ret_ff <= ST_C12;
            ST_FN_POS: ret_ff <= ST_FN_HORNER;
            ST_FN_DL: ret_ff <= ST_FN_EV;
            default: ret_ff <= ret_ff;
         endcase
      end
   end

   // Datapath registers, written on the capture cycle of each multiply and in the setup and output states.
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_sym_ff  <= fsub(q_head.word[oc_ff], ev_ff[oc_ff]);
         rsp_last_ff <= (oc_ff == LAST_POS);
      end
      case (state_ff)
         ST_INIT: begin
            for (int k = 0; k < PARITY_COUNT; k++) s_ff[k] <= '0;
            for (int k = 0; k < CODE_LENGTH; k++) ev_ff[k] <= '0;
            om2_ff     <= '0;
            om3_ff     <= '0;
            beta_ff    <= 10'd1;
            i_ff       <= '0;
            fi_ff      <= 1'b0;
            pw_base_ff <= alpha;
            pw_exp_ff  <= INV_EXP;
            pw_res_ff  <= 10'd1;
         end
         ST_AINV_SAVE: ainv_ff <= pw_res_ff;
         ST_SYN_BETA: begin
            if (ph_ff) begin
               beta_ff <= mul_res;
               acc_ff  <= '0;
               j_ff    <= '0;
            end
         end
         ST_SYN_ACC: begin
            if (ph_ff) begin
               acc_ff <= mul_res;
               j_ff   <= j_ff + 1'b1;
            end
         end
         ST_SYN_STORE: begin
            s_ff[i_ff] <= acc_ff;
            i_ff       <= i_ff + 1'b1;
         end
         // A zero pivot gets exponent zero, so the scale factor is one.
         ST_PIV0: begin
            pw_base_ff <= s_ff[0];
            pw_exp_ff  <= (s_ff[0] != '0) ? INV_EXP : '0;
            pw_res_ff  <= 10'd1;
         end
         ST_A01: if (ph_ff) a01_ff <= mul_res;
         ST_A02: begin
            if (ph_ff) begin
               a02_ff <= mul_res;
               if (!e2) begin
                  l1_ff <= mul_res;
                  l2_ff <= '0;
               end
            end
         end
         ST_B11: if (ph_ff) b11_ff <= mul_res;
         ST_B12: if (ph_ff) b12_ff <= mul_res;
         ST_PIV1: begin
            pw_base_ff <= b11_ff;
            pw_exp_ff  <= (b11_ff != '0) ? INV_EXP : '0;
            pw_res_ff  <= 10'd1;
         end
         ST_C12:  if (ph_ff) l1_ff  <= mul_res;
         ST_L2:   if (ph_ff) l2_ff  <= mul_res;
         ST_OM1:  if (ph_ff) om1_ff <= mul_res;
         ST_OM2A: if (ph_ff) om2_ff <= mul_res;
         ST_OM2B: if (ph_ff) om2_ff <= mul_res;
         ST_OM3A: if (ph_ff) om3_ff <= mul_res;
         ST_OM3B: if (ph_ff) om3_ff <= mul_res;
         // Locate X^-1 = alpha^-pos; out-of-range positions add no error.
         ST_FN_POS: begin
            if (pos_ok) begin
               pw_base_ff <= ainv_ff;
               pw_exp_ff  <= {{(SYM_W - POS_W){1'b0}}, pos_cur};
               pw_res_ff  <= 10'd1;
               acc_ff     <= '0;
               hk_ff      <= 2'd3;
            end else if (fi_ff != e2) begin
               fi_ff <= 1'b1;
            end
         end
         ST_FN_HORNER: begin
            if (ph_ff) begin
               acc_ff <= mul_res;
               hk_ff  <= hk_ff - 1'b1;
            end
         end
         ST_FN_DL: begin
            if (ph_ff) begin
               dl_ff      <= mul_res;
               pw_base_ff <= mul_res;
               pw_exp_ff  <= INV_EXP;
               pw_res_ff  <= 10'd1;
            end
         end
         // A zero derivative leaves the error value untouched.
         ST_FN_EV: begin
            if (ph_ff) begin
               if (dl_ff != '0) begin
                  ev_ff[LAST_POS - pos_cur] <= mul_res;
               end
               if (fi_ff != e2) begin
                  fi_ff <= 1'b1;
               end else begin
                  oc_ff <= '0;
               end
            end
         end
         ST_EMIT: if (load_out) oc_ff <= oc_ff + 1'b1;
         ST_PW_MUL: if (ph_ff) pw_res_ff <= mul_res;
         ST_PW_SQ: begin
            if (ph_ff) begin
               pw_base_ff <= mul_res;
               pw_exp_ff  <= pw_exp_ff >> 1;
            end
         end
         default: begin
         end
      endcase
      // The output counter starts over whenever the skip path enters emission.
      if (state_ff == ST_FN_POS && !pos_ok && fi_ff == e2) begin
         oc_ff <= '0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_corrected_symbol = rsp_sym_ff;
   assign rsp_last_of_run      = rsp_last_ff;

   `RSGF_IMPLY(a_emit_has_job, state_ff == ST_EMIT, q_valid)
   `RSGF_IMPLY(a_pop_on_last_load, pop, load_out && (oc_ff == LAST_POS))
   `RSGF_IMPLY(a_idle_phase_clear, state_ff == ST_IDLE, !ph_ff)

endmodule

// ===== rtl/rs_gf929_known_position_decoder_unit.sv =====
// Symbols that do not end a word are taken one per cycle while the job queue has room.
// After the end-of-word request the corrected symbols follow one per cycle unless stalled.
// The wait for the first one is set by up to five field inversions on the single shared
// multiply-add unit, with the syndrome passes and the Forney steps.
// Reset clears the sequencer state, the queue and the output valid flag, and loads generator 3 and two assumed errors.
module rs_gf929_known_position_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [9:0] req_symbol,
   input  logic [2:0] req_first_error_position,
   input  logic [2:0] req_second_error_position,
   input  logic       req_end_of_word,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [9:0] rsp_corrected_symbol,
   output logic       rsp_last_of_run,
   input  logic       csr_write,
   input  logic [0:0] csr_index,
   input  logic [9:0] csr_data
);
   import rsgf_pkg::*;

   cfg_type     cfg_ff;
   logic        q_full;
   logic        q_valid;
   logic        push;
   logic        pop;
   job_type     push_job;
   job_type     q_head;
   mul_req_type mul_req;
   logic [SYM_W-1:0] mul_res;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.generator      <= 10'd3;
         cfg_ff.errors_assumed <= 2'd2;
      end else if (csr_write) begin
         case (csr_index)
            CSR_GENERATOR: cfg_ff.generator      <= csr_data;
            CSR_ERRORS:    cfg_ff.errors_assumed <= csr_data[1:0];
            default:       cfg_ff <= cfg_ff;
         endcase
      end
   end

   rsgf_front u_front (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_symbol                (req_symbol),
      .req_first_error_position  (req_first_error_position),
      .req_second_error_position (req_second_error_position),
      .req_end_of_word           (req_end_of_word),
      .q_full                    (q_full),
      .push                      (push),
      .job                       (push_job)
   );

   rsgf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (q_full),
      .q_valid  (q_valid),
      .q_head   (q_head)
   );

   rsgf_mul u_mul (
      .clock  (clock),
      .req    (mul_req),
      .result (mul_res)
   );

   rsgf_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .q_valid              (q_valid),
      .q_head               (q_head),
      .pop                  (pop),
      .mul_req              (mul_req),
      .mul_res              (mul_res),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_corrected_symbol (rsp_corrected_symbol),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule
